@@ sv/cbc_pkg.sv @@
// Shared types and constants of the cartridge bank controller.
package cbc_pkg;

	localparam int unsigned MAX_ROM_BANKS_LOG2 = 9;
	localparam int unsigned MAX_RAM_BANKS_LOG2 = 4;
	localparam int unsigned NIBBLE_RAM_DEPTH   = 512;
	localparam int unsigned NRAM_AW            = $clog2(NIBBLE_RAM_DEPTH);
	localparam int unsigned NRAM_DW            = 4;

	localparam logic [1:0] CFG_CART_TYPE      = 2'd0;
	localparam logic [1:0] CFG_ROM_BANKS_LOG2 = 2'd1;
	localparam logic [1:0] CFG_RAM_BANKS_LOG2 = 2'd2;
	localparam logic [1:0] CFG_MULTICART      = 2'd3;

	typedef enum logic [1:0] {
		TGT_NONE = 2'd0,
		TGT_ROM  = 2'd1,
		TGT_RAM  = 2'd2,
		TGT_DATA = 2'd3
	} target_t;

	typedef enum logic [2:0] {
		KIND_NONE,
		KIND_ONE,
		KIND_TWO,
		KIND_THREE,
		KIND_FIVE
	} kind_t;

	typedef struct packed {
		logic               we;
		logic               re;
		logic [NRAM_AW-1:0] addr;
		logic [NRAM_DW-1:0] wdata;
	} nram_req_t;

endpackage

@@ sv/cbc_nram.sv @@
// Internal nibble RAM with its clearing sweep after reset.
module cbc_nram (
	input  logic                           clk,
	input  logic                           arst_n,
	input  cbc_pkg::nram_req_t             req,
	output logic [cbc_pkg::NRAM_DW-1:0]    rdata,
	output logic                           ready
);

	logic [cbc_pkg::NRAM_DW-1:0] mem [cbc_pkg::NIBBLE_RAM_DEPTH];
	logic [cbc_pkg::NRAM_DW-1:0] rdata_q;
	logic [cbc_pkg::NRAM_AW-1:0] clr_addr_q;
	logic                        clr_busy_q;

	logic                        mem_we;
	logic [cbc_pkg::NRAM_AW-1:0] mem_wa;
	logic [cbc_pkg::NRAM_DW-1:0] mem_wd;

	always_comb begin
		if (clr_busy_q) begin
			mem_we = 1'b1;
			mem_wa = clr_addr_q;
			mem_wd = '0;
		end else begin
			mem_we = req.we;
			mem_wa = req.addr;
			mem_wd = req.wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == {cbc_pkg::NRAM_AW{1'b1}}) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (req.re) begin
			rdata_q <= mem[req.addr];
		end
	end

	assign rdata = rdata_q;
	assign ready = !clr_busy_q;

endmodule

@@ sv/cartridge_bank_controller_unit.sv @@
// Cartridge bank controller: bank registers, address mapping and output stage.
// Pipeline: an accepted request is registered in stage s1, then in the output register.
// Throughput: one request per cycle unless the output stalls; bank registers update at
// the accepting edge; the output register takes the registered nibble RAM read data.
// Reset: asynchronous; bank and configuration registers take their reset values,
// then a sweep zeroes all 512 nibble RAM entries while s_tready stays low.
module cartridge_bank_controller_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // address[15:0], write_data[23:16]
	input  logic [0:0]  s_tuser,   // opcode[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // rom_address[22:0], ram_address[39:23], read_data[47:40]
	output logic [1:0]  m_tuser,   // target[1:0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	localparam logic [7:0] SEL_SECONDS  = 8'h08;
	localparam logic [7:0] SEL_MINUTES  = 8'h09;
	localparam logic [7:0] SEL_HOURS    = 8'h0A;
	localparam logic [7:0] SEL_DAY_LOW  = 8'h0B;
	localparam logic [7:0] SEL_DAY_HIGH = 8'h0C;

	function automatic cbc_pkg::kind_t kind_of(input logic [7:0] t);
		cbc_pkg::kind_t k;
		k = cbc_pkg::KIND_NONE;
		if (t >= 8'h01 && t <= 8'h03) k = cbc_pkg::KIND_ONE;
		else if (t >= 8'h05 && t <= 8'h06) k = cbc_pkg::KIND_TWO;
		else if (t >= 8'h0F && t <= 8'h13) k = cbc_pkg::KIND_THREE;
		else if (t >= 8'h19 && t <= 8'h1E) k = cbc_pkg::KIND_FIVE;
		return k;
	endfunction

	function automatic logic enable_bit(input logic [7:0] v);
		return v[3:0] == 4'hA;
	endfunction

	function automatic logic [5:0] mod60(input logic [7:0] v);
		logic [5:0] h;
		logic [3:0] r;
		h = v[7:2];
		if (h >= 6'd60) r = 4'(h - 6'd60);
		else if (h >= 6'd45) r = 4'(h - 6'd45);
		else if (h >= 6'd30) r = 4'(h - 6'd30);
		else if (h >= 6'd15) r = 4'(h - 6'd15);
		else r = h[3:0];
		return {r, v[1:0]};
	endfunction

	function automatic logic [4:0] mod24(input logic [7:0] v);
		logic [4:0] h;
		logic [8:0] p;
		logic [3:0] q;
		logic [5:0] r;
		h = v[7:3];
		p = 9'(h) * 9'd11;
		q = p[8:5];
		r = 6'(h) - 6'(6'(q) * 6'd3);
		if (r >= 6'd3) r = r - 6'd3;
		return {r[1:0], v[2:0]};
	endfunction

	logic [7:0] cart_type_q;
	logic [3:0] rom_log2_q;
	logic [2:0] ram_log2_q;
	logic       multicart_q;

	logic       k1_ram_en_q;
	logic [4:0] k1_low_q;
	logic [1:0] k1_upper_q;
	logic       k1_mode_q;
	logic       k2_ram_en_q;
	logic [3:0] k2_rom_q;
	logic       k3_ram_en_q;
	logic [6:0] k3_rom_q;
	logic [7:0] k3_sel_q;
	logic [5:0] rtc_sec_q;
	logic [5:0] rtc_min_q;
	logic [4:0] rtc_hour_q;
	logic [8:0] rtc_days_q;
	logic       rtc_carry_q;
	logic       rtc_halt_q;
	logic       k5_ram_en_q;
	logic [7:0] k5_rom_low_q;
	logic       k5_rom_high_q;
	logic [3:0] k5_ram_bank_q;

	logic             valid_s1;
	cbc_pkg::target_t tgt_s1;
	logic [22:0]      rom_a_s1;
	logic [16:0]      ram_a_s1;
	logic [7:0]       data_s1;
	logic             nib_s1;

	logic             out_valid_q;
	cbc_pkg::target_t out_tgt_q;
	logic [22:0]      out_rom_q;
	logic [16:0]      out_ram_q;
	logic [7:0]       out_data_q;

	cbc_pkg::kind_t                kind;
	cbc_pkg::nram_req_t            nram_req;
	logic [cbc_pkg::NRAM_DW-1:0]   nram_rdata;
	logic                          nram_ready;

	logic        s_accept;
	logic        s1_adv;
	logic        wr;
	logic [15:0] a;
	logic [7:0]  v;
	logic        in_rom;
	logic        in_ram;
	logic [3:0]  rom_l;
	logic [8:0]  rom_mask;
	logic [2:0]  ram_l;
	logic [3:0]  ram_mask;
	logic [8:0]  rom_bank;
	logic [4:0]  k1_eff;
	logic        ram_enabled;
	logic [3:0]  ram_bank;
	logic [7:0]  rtc_data;
	logic        rtc_path;

	cbc_pkg::target_t tgt_c;
	logic [22:0]      rom_a_c;
	logic [16:0]      ram_a_c;
	logic [7:0]       data_c;
	logic             nib_c;

	assign kind     = kind_of(cart_type_q);
	assign wr       = s_tuser[0];
	assign a        = s_tdata[15:0];
	assign v        = s_tdata[23:16];
	assign in_rom   = !a[15];
	assign in_ram   = a[15:13] == 3'b101;
	assign s1_adv   = !out_valid_q || m_tready;
	assign s_tready = nram_ready && (!valid_s1 || s1_adv);
	assign s_accept = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	always_comb begin
		if (rom_log2_q < 4'd1) rom_l = 4'd1;
		else if (rom_log2_q > 4'(cbc_pkg::MAX_ROM_BANKS_LOG2))
			rom_l = 4'(cbc_pkg::MAX_ROM_BANKS_LOG2);
		else rom_l = rom_log2_q;
		rom_mask = 9'((10'd1 << rom_l) - 10'd1);
		if (ram_log2_q > 3'(cbc_pkg::MAX_RAM_BANKS_LOG2))
			ram_l = 3'(cbc_pkg::MAX_RAM_BANKS_LOG2);
		else ram_l = ram_log2_q;
		ram_mask = 4'((5'd1 << ram_l) - 5'd1);
	end

	always_comb begin
		k1_eff = (k1_low_q == 5'd0) ? 5'd1 : k1_low_q;
		rom_bank = '0;
		priority if (kind == cbc_pkg::KIND_ONE) begin
			if (!a[14]) begin
				if (k1_mode_q) rom_bank = multicart_q ? {3'b0, k1_upper_q, 4'b0}
					: {2'b0, k1_upper_q, 5'b0};
			end else if (multicart_q) begin
				rom_bank = {3'b0, k1_upper_q, k1_eff[3:0]};
			end else begin
				rom_bank = {2'b0, k1_upper_q, k1_eff};
			end
			rom_bank = rom_bank & rom_mask;
		end else if (kind == cbc_pkg::KIND_NONE || !a[14]) begin
			rom_bank = {8'b0, a[14]};
		end else if (kind == cbc_pkg::KIND_TWO) begin
			rom_bank = ((k2_rom_q == 4'd0) ? 9'd1 : {5'b0, k2_rom_q}) & rom_mask;
		end else if (kind == cbc_pkg::KIND_THREE) begin
			rom_bank = {2'b0, k3_rom_q} & rom_mask;
		end else begin
			rom_bank = {k5_rom_high_q, k5_rom_low_q} & rom_mask;
		end
	end

	always_comb begin
		unique case (kind)
			cbc_pkg::KIND_ONE:   ram_enabled = k1_ram_en_q;
			cbc_pkg::KIND_TWO:   ram_enabled = k2_ram_en_q;
			cbc_pkg::KIND_THREE: ram_enabled = k3_ram_en_q;
			cbc_pkg::KIND_FIVE:  ram_enabled = k5_ram_en_q;
			default:             ram_enabled = 1'b1;
		endcase
		priority if (kind == cbc_pkg::KIND_ONE && k1_mode_q) ram_bank = {2'b0, k1_upper_q};
		else if (kind == cbc_pkg::KIND_THREE) ram_bank = k3_sel_q[3:0];
		else if (kind == cbc_pkg::KIND_FIVE) ram_bank = k5_ram_bank_q;
		else ram_bank = '0;
		rtc_path = kind == cbc_pkg::KIND_THREE && k3_sel_q > 8'd3;
		unique case (k3_sel_q)
			SEL_SECONDS:  rtc_data = {2'b0, rtc_sec_q};
			SEL_MINUTES:  rtc_data = {2'b0, rtc_min_q};
			SEL_HOURS:    rtc_data = {3'b0, rtc_hour_q};
			SEL_DAY_LOW:  rtc_data = rtc_days_q[7:0];
			SEL_DAY_HIGH: rtc_data = {rtc_carry_q, rtc_halt_q, 5'b0, rtc_days_q[8]};
			default:      rtc_data = 8'hFF;
		endcase
	end

	always_comb begin
		tgt_c   = cbc_pkg::TGT_NONE;
		rom_a_c = '0;
		ram_a_c = '0;
		data_c  = '0;
		nib_c   = 1'b0;
		if (in_rom) begin
			if (!wr) begin
				tgt_c   = cbc_pkg::TGT_ROM;
				rom_a_c = {rom_bank, a[13:0]};
			end
		end else if (in_ram) begin
			priority if (!ram_enabled) begin
				if (!wr) begin
					tgt_c  = cbc_pkg::TGT_DATA;
					data_c = 8'hFF;
				end
			end else if (kind == cbc_pkg::KIND_TWO) begin
				if (!wr) begin
					tgt_c = cbc_pkg::TGT_DATA;
					nib_c = 1'b1;
				end
			end else if (rtc_path) begin
				if (!wr) begin
					tgt_c  = cbc_pkg::TGT_DATA;
					data_c = rtc_data;
				end
			end else begin
				tgt_c   = cbc_pkg::TGT_RAM;
				ram_a_c = {ram_bank & ram_mask, a[12:0]};
			end
		end
	end

	always_comb begin
		nram_req.re    = s_accept;
		nram_req.we    = s_accept && wr && in_ram && ram_enabled
			&& kind == cbc_pkg::KIND_TWO;
		nram_req.addr  = a[cbc_pkg::NRAM_AW-1:0];
		nram_req.wdata = v[cbc_pkg::NRAM_DW-1:0];
	end

	cbc_nram u_nram (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (nram_req),
		.rdata  (nram_rdata),
		.ready  (nram_ready)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cart_type_q   <= '0;
			rom_log2_q    <= 4'd1;
			ram_log2_q    <= '0;
			multicart_q   <= 1'b0;
			k1_ram_en_q   <= 1'b0;
			k1_low_q      <= '0;
			k1_upper_q    <= '0;
			k1_mode_q     <= 1'b0;
			k2_ram_en_q   <= 1'b0;
			k2_rom_q      <= '0;
			k3_ram_en_q   <= 1'b0;
			k3_rom_q      <= 7'd1;
			k3_sel_q      <= '0;
			rtc_sec_q     <= '0;
			rtc_min_q     <= '0;
			rtc_hour_q    <= '0;
			rtc_days_q    <= '0;
			rtc_carry_q   <= 1'b0;
			rtc_halt_q    <= 1'b1;
			k5_ram_en_q   <= 1'b0;
			k5_rom_low_q  <= 8'd1;
			k5_rom_high_q <= 1'b0;
			k5_ram_bank_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					cbc_pkg::CFG_CART_TYPE:      cart_type_q <= cfg_data;
					cbc_pkg::CFG_ROM_BANKS_LOG2: rom_log2_q  <= cfg_data[3:0];
					cbc_pkg::CFG_RAM_BANKS_LOG2: ram_log2_q  <= cfg_data[2:0];
					cbc_pkg::CFG_MULTICART:      multicart_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (s_accept && wr && in_rom) begin
				unique case (kind)
					cbc_pkg::KIND_ONE: begin
						unique case (a[14:13])
							2'b00: k1_ram_en_q <= enable_bit(v);
							2'b01: k1_low_q    <= v[4:0];
							2'b10: k1_upper_q  <= v[1:0];
							default: k1_mode_q <= v[0];
						endcase
					end
					cbc_pkg::KIND_TWO: begin
						if (!a[14]) begin
							if (a[8]) k2_rom_q <= v[3:0];
							else k2_ram_en_q <= enable_bit(v);
						end
					end
					cbc_pkg::KIND_THREE: begin
						unique case (a[14:13])
							2'b00: k3_ram_en_q <= enable_bit(v);
							2'b01: k3_rom_q    <= (v[6:0] == 7'd0) ? 7'd1 : v[6:0];
							2'b10: k3_sel_q    <= v;
							default: ;
						endcase
					end
					cbc_pkg::KIND_FIVE: begin
						priority if (a[14:13] == 2'b00) k5_ram_en_q <= enable_bit(v);
						else if (a[14:12] == 3'b010) k5_rom_low_q <= v;
						else if (a[14:12] == 3'b011) k5_rom_high_q <= v[0];
						else if (a[14:13] == 2'b10) k5_ram_bank_q <= v[3:0];
						else ;
					end
					default: ;
				endcase
			end
			if (s_accept && wr && in_ram && ram_enabled && rtc_path) begin
				unique case (k3_sel_q)
					SEL_SECONDS:  rtc_sec_q  <= mod60(v);
					SEL_MINUTES:  rtc_min_q  <= mod60(v);
					SEL_HOURS:    rtc_hour_q <= mod24(v);
					SEL_DAY_LOW:  rtc_days_q[7:0] <= v;
					SEL_DAY_HIGH: begin
						rtc_days_q[8] <= v[0];
						rtc_carry_q   <= v[7];
						rtc_halt_q    <= v[6];
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_accept) valid_s1 <= 1'b1;
			else if (s1_adv) valid_s1 <= 1'b0;
			if (s1_adv) out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			tgt_s1   <= tgt_c;
			rom_a_s1 <= rom_a_c;
			ram_a_s1 <= ram_a_c;
			data_s1  <= data_c;
			nib_s1   <= nib_c;
		end
		if (s1_adv && valid_s1) begin
			out_tgt_q  <= tgt_s1;
			out_rom_q  <= rom_a_s1;
			out_ram_q  <= ram_a_s1;
			out_data_q <= nib_s1 ? {4'hF, nram_rdata} : data_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_tgt_q;
	assign m_tdata  = {out_data_q, out_ram_q, out_rom_q};

`ifndef SYNTHESIS
	a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		!nram_ready |-> !s_tready)
		else $error("request accepted during nibble RAM sweep");

	a_nibble_is_data: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && nib_s1 |-> tgt_s1 == cbc_pkg::TGT_DATA)
		else $error("nibble read without data target");

	a_rom_field_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != cbc_pkg::TGT_ROM |-> m_tdata[22:0] == 23'd0)
		else $error("ROM address set on non-ROM result");

	a_k3_bank_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		k3_rom_q != 7'd0)
		else $error("MBC3 ROM bank register holds zero");

	a_stage_moves: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && s1_adv && !s_accept |=> out_valid_q && !valid_s1)
		else $error("pipeline stage lost a request");
`endif

endmodule
